### rtl/srf_pkg.sv
// Shared types and constants for the signed radix formatter.
// No dependencies; imported by the top level and the digit divider.
`timescale 1ns / 1ps

package srf_pkg;

  localparam int SYMBOL_W   = 8;   // alphabet symbol / output character width
  localparam int INDEX_W    = 6;   // symbol_index port width
  localparam int BASE_LEN_W = 7;   // base_length register width
  localparam int DIGIT_W    = BASE_LEN_W;  // a digit is below the radix

  localparam logic [BASE_LEN_W-1:0] BASE_LEN_RESET = 7'd10;

  localparam logic [SYMBOL_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [SYMBOL_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [SYMBOL_W-1:0] CHAR_NONE  = 8'h00;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

endpackage

### rtl/signed_radix_formatter.sv
// Top level of the signed radix formatter: request sequencer, alphabet check
// and character output. Depends on srf_pkg, srf_ram and srf_divider.
`timescale 1ns / 1ps

// Usage
//   Requests: a request is taken on a rising edge with start high and busy low.
//   op = load writes symbol_code to alphabet slot symbol_index (slots at or
//   beyond MAX_BASE are ignored); it completes in that cycle, busy stays low
//   and nothing is emitted. op = convert formats number in the radix set by
//   base_length, using the loaded alphabet; busy is high until the last
//   character has been put out.
//   Results: each character is on out_char/last_char/status for exactly one
//   cycle with result_strobe high; the receiver cannot stall, so it must take
//   every strobe. A bad alphabet gives one strobe with status high.
//   base_length is written with base_length_we only while busy is low: a rule
//   for the user, as the block itself does not enforce it.
//   Steps of a convert request: a base out of range gives one result the cycle
//   after the request, with no busy. Otherwise the check reads each symbol in
//   use and compares it with every later one, then the bit-serial divider
//   produces the digits one by one, and the output gives a minus first for a
//   negative number, then the digits, most significant first.
//   Reset (rst, synchronous): sequencer idle, base_length back to 10, no
//   strobe. The alphabet and digit buffer hold no reset value.
module signed_radix_formatter #(
  parameter int MAX_BASE     = 64,
  parameter int NUMBER_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                op,
  input  logic [srf_pkg::INDEX_W-1:0]         symbol_index,
  input  logic [srf_pkg::SYMBOL_W-1:0]        symbol_code,
  input  logic signed [NUMBER_WIDTH-1:0]      number,
  input  logic                                base_length_we,
  input  logic [srf_pkg::BASE_LEN_W-1:0]      base_length,
  output logic                                result_strobe,
  output logic [srf_pkg::SYMBOL_W-1:0]        out_char,
  output logic                                last_char,
  output logic                                status
);

  import srf_pkg::*;

  localparam int AW    = $clog2(MAX_BASE);        // alphabet address
  localparam int DAW   = $clog2(NUMBER_WIDTH);    // digit buffer address
  localparam int DCNT_W = $clog2(NUMBER_WIDTH + 1);
  localparam logic [8:0] MAX_BASE_V = 9'(MAX_BASE);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK_ADDR,   // present address of the symbol under test
    ST_CHK_HOLD,   // symbol back from RAM: test sign chars, keep it
    ST_CMP_ADDR,   // present address of a later symbol
    ST_CMP_TEST,   // later symbol back from RAM: test for a duplicate
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT_SIGN,
    ST_EMIT_DADDR, // read digit buffer
    ST_EMIT_SADDR, // look digit up in alphabet
    ST_EMIT_OUT
  } state_t;

  state_t                  state;
  logic [BASE_LEN_W-1:0]   base_cfg;
  logic [BASE_LEN_W-1:0]   chk_idx;
  logic [BASE_LEN_W-1:0]   cmp_idx;
  logic [SYMBOL_W-1:0]     chk_sym;       // symbol held for the pairwise compare
  logic                    neg;
  logic [NUMBER_WIDTH-1:0] magnitude;
  logic [DCNT_W-1:0]       digit_count;
  logic [DCNT_W-1:0]       emit_cnt;

  logic                    accept;
  logic                    base_bad;
  logic [NUMBER_WIDTH-1:0] number_u;

  logic                    alpha_we;
  logic [AW-1:0]           alpha_raddr;
  logic [SYMBOL_W-1:0]     alpha_rdata;
  logic                    sign_bad;

  logic                    digit_we;
  logic [DAW-1:0]          digit_raddr;
  logic [DIGIT_W-1:0]      digit_rdata;

  logic                    div_start;
  logic                    div_done;
  logic [NUMBER_WIDTH-1:0] div_quo;
  logic [DIGIT_W-1:0]      div_rem;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign number_u = number;
  assign base_bad = (base_cfg < BASE_LEN_W'(2)) || ({2'b00, base_cfg} > MAX_BASE_V);

  // Load requests go straight into the alphabet RAM.
  assign alpha_we = accept && (op == OP_LOAD) &&
                    ({3'b000, symbol_index} < MAX_BASE_V);
  assign alpha_raddr = (state == ST_EMIT_SADDR) ? AW'(digit_rdata) :
                       (state == ST_CMP_ADDR)   ? AW'(cmp_idx) : AW'(chk_idx);
  assign sign_bad = (alpha_rdata == CHAR_PLUS) || (alpha_rdata == CHAR_MINUS);

  srf_ram #(
    .WIDTH (SYMBOL_W),
    .DEPTH (MAX_BASE)
  ) u_alphabet (
    .clk   (clk),
    .we    (alpha_we),
    .waddr (AW'(symbol_index)),
    .wdata (symbol_code),
    .raddr (alpha_raddr),
    .rdata (alpha_rdata)
  );

  // Digits are stored least significant first, read back in reverse.
  assign digit_we    = (state == ST_DIV_WAIT) && div_done;
  assign digit_raddr = DAW'(emit_cnt - 1'b1);

  srf_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (NUMBER_WIDTH)
  ) u_digits (
    .clk   (clk),
    .we    (digit_we),
    .waddr (DAW'(digit_count)),
    .wdata (div_rem),
    .raddr (digit_raddr),
    .rdata (digit_rdata)
  );

  assign div_start = (state == ST_DIV_START);

  srf_divider #(
    .WIDTH (NUMBER_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (magnitude),
    .divisor   (base_cfg),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      base_cfg      <= BASE_LEN_RESET;
      result_strobe <= 1'b0;
      digit_count   <= '0;
      magnitude     <= '0;
    end else begin
      result_strobe <= 1'b0;
      if (base_length_we) begin
        base_cfg <= base_length;
      end

      case (state)
        ST_IDLE: begin
          if (accept && (op == OP_CONVERT)) begin
            if (base_bad) begin
              result_strobe <= 1'b1;
              out_char      <= CHAR_NONE;
              last_char     <= 1'b1;
              status        <= STATUS_BAD;
            end else begin
              neg       <= number_u[NUMBER_WIDTH-1];
              magnitude <= number_u[NUMBER_WIDTH-1] ? (~number_u + 1'b1) : number_u;
              chk_idx   <= '0;
              state     <= ST_CHK_ADDR;
            end
          end
        end

        ST_CHK_ADDR: begin
          state <= ST_CHK_HOLD;
        end

        ST_CHK_HOLD: begin
          if (sign_bad) begin
            result_strobe <= 1'b1;
            out_char      <= CHAR_NONE;
            last_char     <= 1'b1;
            status        <= STATUS_BAD;
            state         <= ST_IDLE;
          end else begin
            chk_sym <= alpha_rdata;
            cmp_idx <= chk_idx + 1'b1;
            // last symbol in use has no later one to compare against
            if (chk_idx + 1'b1 == base_cfg) begin
              digit_count <= '0;
              state       <= ST_DIV_START;
            end else begin
              state <= ST_CMP_ADDR;
            end
          end
        end

        ST_CMP_ADDR: begin
          state <= ST_CMP_TEST;
        end

        ST_CMP_TEST: begin
          if (alpha_rdata == chk_sym) begin
            result_strobe <= 1'b1;
            out_char      <= CHAR_NONE;
            last_char     <= 1'b1;
            status        <= STATUS_BAD;
            state         <= ST_IDLE;
          end else if (cmp_idx + 1'b1 == base_cfg) begin
            chk_idx <= chk_idx + 1'b1;
            state   <= ST_CHK_ADDR;
          end else begin
            cmp_idx <= cmp_idx + 1'b1;
            state   <= ST_CMP_ADDR;
          end
        end

        ST_DIV_START: begin
          state <= ST_DIV_WAIT;
        end

        ST_DIV_WAIT: begin
          if (div_done) begin
            magnitude   <= div_quo;
            digit_count <= digit_count + 1'b1;
            if (div_quo == '0) begin
              emit_cnt <= digit_count + 1'b1;
              state    <= neg ? ST_EMIT_SIGN : ST_EMIT_DADDR;
            end else begin
              state <= ST_DIV_START;
            end
          end
        end

        ST_EMIT_SIGN: begin
          result_strobe <= 1'b1;
          out_char      <= CHAR_MINUS;
          last_char     <= 1'b0;
          status        <= STATUS_OK;
          state         <= ST_EMIT_DADDR;
        end

        ST_EMIT_DADDR: begin
          state <= ST_EMIT_SADDR;
        end

        ST_EMIT_SADDR: begin
          state <= ST_EMIT_OUT;
        end

        ST_EMIT_OUT: begin
          result_strobe <= 1'b1;
          out_char      <= alpha_rdata;
          last_char     <= (emit_cnt == DCNT_W'(1));
          status        <= STATUS_OK;
          emit_cnt      <= emit_cnt - 1'b1;
          state         <= (emit_cnt == DCNT_W'(1)) ? ST_IDLE : ST_EMIT_DADDR;
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/srf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the alphabet and the digit buffer.
`timescale 1ns / 1ps

module srf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/srf_divider.sv
// Bit-serial restoring divider: WIDTH-bit dividend by a radix-sized divisor.
// Depends on srf_pkg for the digit width. One quotient bit per cycle.
`timescale 1ns / 1ps

module srf_divider #(
  parameter int WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [WIDTH-1:0]           dividend,
  input  logic [srf_pkg::DIGIT_W-1:0] divisor,
  output logic                       done,
  output logic [WIDTH-1:0]           quotient,
  output logic [srf_pkg::DIGIT_W-1:0] remainder
);

  import srf_pkg::*;

  localparam int CNT_W = $clog2(WIDTH);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WIDTH - 1);

  logic             running;
  logic [CNT_W-1:0] step;
  logic [DIGIT_W:0] partial;
  logic             fits;
  logic [DIGIT_W:0] diff;

  // partial remainder with the next dividend bit shifted in
  assign partial = {remainder, quotient[WIDTH-1]};
  assign fits    = partial >= {1'b0, divisor};
  assign diff    = partial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running   <= 1'b1;
        step      <= '0;
        quotient  <= dividend;
        remainder <= '0;
      end else if (running) begin
        quotient  <= {quotient[WIDTH-2:0], fits};
        remainder <= fits ? diff[DIGIT_W-1:0] : partial[DIGIT_W-1:0];
        step      <= step + 1'b1;
        if (step == LAST_STEP) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

### test/tb_signed_radix_formatter.sv
// Self-checking testbench for signed_radix_formatter: loads digit alphabets, converts numbers
// and checks every output character against a built-in formatter model.
// Depends on srf_pkg and the RTL of signed_radix_formatter; reads no files.
`timescale 1ns / 1ps

module tb_signed_radix_formatter;
  import srf_pkg::*;

  localparam int MAX_BASE     = 64;
  localparam int NUM_W        = 32;
  localparam int RANDOM_ITEMS = 90;
  localparam int QUIET_TAIL   = 30;     // last requests sent back to back
  localparam int STALL_LIMIT  = 20000;  // cycles with no request and no character

  // One expected character on the result ports
  typedef struct packed {
    logic [SYMBOL_W-1:0] ch;
    logic                last;
    logic                st;
  } char_result_t;

  // Formatter model plus the queue of characters still owed by the block.
  // Each accepted request goes through note_request, each strobe through check_result.
  class radix_scoreboard;
    logic [SYMBOL_W-1:0]   alphabet [MAX_BASE];
    logic [BASE_LEN_W-1:0] radix;
    char_result_t          owed_chars [$];
    int                    errors;

    function new();
      radix  = BASE_LEN_RESET;
      errors = 0;
    endfunction

    function void set_radix(logic [BASE_LEN_W-1:0] r);
      radix = r;
    endfunction

    function int pending();
      return owed_chars.size();
    endfunction

    // Radix in range, no sign characters, no repeated symbol among the ones in use
    function bit alphabet_valid();
      if (radix < 2 || radix > MAX_BASE) return 1'b0;
      for (int a = 0; a < radix; a++) begin
        if (alphabet[a] == CHAR_PLUS || alphabet[a] == CHAR_MINUS) return 1'b0;
        for (int b = a + 1; b < radix; b++)
          if (alphabet[a] == alphabet[b]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_request(logic o, logic [INDEX_W-1:0] idx, logic [SYMBOL_W-1:0] code,
                               logic signed [NUM_W-1:0] num);
      bit [NUM_W-1:0] mag;
      int             digits [$];
      if (o == OP_LOAD) begin
        alphabet[idx] = code;
        return;
      end
      if (!alphabet_valid()) begin
        owed_chars.push_back('{CHAR_NONE, 1'b1, STATUS_BAD});
        return;
      end
      // unsigned negate keeps the most negative value intact
      mag = num[NUM_W-1] ? (~num + 1'b1) : num;
      do begin
        digits.push_back(int'(mag % radix));
        mag = mag / radix;
      end while (mag != 0);
      if (num[NUM_W-1]) owed_chars.push_back('{CHAR_MINUS, 1'b0, STATUS_OK});
      for (int i = digits.size() - 1; i >= 0; i--)
        owed_chars.push_back('{alphabet[digits[i]], i == 0, STATUS_OK});
    endfunction

    function void check_result(logic [SYMBOL_W-1:0] ch, logic last, logic st);
      char_result_t want;
      if (owed_chars.size() == 0) begin
        $display("%0t: character with none expected: out_char %h last_char %b status %b",
                 $time, ch, last, st);
        errors++;
        return;
      end
      want = owed_chars.pop_front();
      if (ch !== want.ch) begin
        $display("%0t: out_char expected %h actual %h", $time, want.ch, ch);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last_char expected %b actual %b", $time, want.last, last);
        errors++;
      end
      if (st !== want.st) begin
        $display("%0t: status expected %b actual %b", $time, want.st, st);
        errors++;
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    op = OP_LOAD;
  logic [INDEX_W-1:0]      symbol_index = '0;
  logic [SYMBOL_W-1:0]     symbol_code = '0;
  logic signed [NUM_W-1:0] number = '0;
  logic                    base_length_we = 1'b0;
  logic [BASE_LEN_W-1:0]   base_length = BASE_LEN_RESET;
  logic                    result_strobe;
  logic [SYMBOL_W-1:0]     out_char;
  logic                    last_char;
  logic                    status;

  radix_scoreboard sb = new();

  // Stimulus-side copy of the alphabet, updated when a load is issued, so that
  // code choices never race the monitor at the same edge.
  logic [SYMBOL_W-1:0] shadow [MAX_BASE];
  int                  sent_count = 0;
  bit                  quiet = 1'b0;     // no sender gaps while set
  int                  idle_cycles = 0;

  signed_radix_formatter #(
    .MAX_BASE    (MAX_BASE),
    .NUMBER_WIDTH(NUM_W)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .symbol_index  (symbol_index),
    .symbol_code   (symbol_code),
    .number        (number),
    .base_length_we(base_length_we),
    .base_length   (base_length),
    .result_strobe (result_strobe),
    .out_char      (out_char),
    .last_char     (last_char),
    .status        (status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Monitor and watchdog. Signals are read right after the edge, before any
  // nonblocking update, so they hold what the block saw at that edge.
  // The character is checked before a request taken at the same edge is noted:
  // it always belongs to an earlier request.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_strobe) sb.check_result(out_char, last_char, status);
      if (start && !busy) sb.note_request(op, symbol_index, symbol_code, number);
      if (result_strobe || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Present one request and hold it until the block takes it. start stays high
  // on return so back-to-back requests need no second assignment in a step.
  task automatic send_request(input logic o, input logic [INDEX_W-1:0] idx,
                              input logic [SYMBOL_W-1:0] code,
                              input logic signed [NUM_W-1:0] num);
    start        <= 1'b1;
    op           <= o;
    symbol_index <= idx;
    symbol_code  <= code;
    number       <= num;
    if (o == OP_LOAD) shadow[idx] = code;
    sent_count++;
    do @(posedge clk); while (busy);
  endtask

  // Unused fields carry random bits so every input bit toggles
  task automatic load_symbol(input int idx, input logic [SYMBOL_W-1:0] code);
    send_request(OP_LOAD, INDEX_W'(idx), code, $urandom());
  endtask

  task automatic convert(input logic signed [NUM_W-1:0] num);
    send_request(OP_CONVERT, INDEX_W'($urandom_range(0, MAX_BASE - 1)),
                 SYMBOL_W'($urandom_range(0, 255)), num);
  endtask

  // Random sender gap, skipped in quiet stretches
  task automatic maybe_pause();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Radix changes only with the block idle and every character delivered
  task automatic write_radix(input logic [BASE_LEN_W-1:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    base_length_we <= 1'b1;
    base_length    <= value;
    @(posedge clk);
    sb.set_radix(value);
    base_length_we <= 1'b0;
  endtask

  // A code that is no sign and not yet anywhere in the alphabet
  function automatic logic [SYMBOL_W-1:0] fresh_code();
    logic [SYMBOL_W-1:0] c;
    bit                  taken;
    do begin
      c     = SYMBOL_W'($urandom_range(0, 255));
      taken = (c == CHAR_PLUS || c == CHAR_MINUS);
      foreach (shadow[j]) if (shadow[j] === c) taken = 1'b1;
    end while (taken);
    return c;
  endfunction

  // Replace every sign or repeated symbol below the radix so conversions get past the check
  task automatic repair_alphabet(input int radix);
    bit clash;
    for (int i = 0; i < radix; i++) begin
      clash = (shadow[i] == CHAR_PLUS || shadow[i] == CHAR_MINUS);
      foreach (shadow[j]) if (j != i && shadow[j] == shadow[i]) clash = 1'b1;
      if (clash) begin
        maybe_pause();
        load_symbol(i, fresh_code());
      end
    end
  endtask

  function automatic logic signed [NUM_W-1:0] pick_number();
    logic signed [NUM_W-1:0] n;
    case ($urandom_range(0, 5))
      0: n = $urandom();
      1: n = $urandom_range(0, 40);
      2: begin
        case ($urandom_range(0, 4))
          0: n = 0;
          1: n = 1;
          2: n = -1;
          3: n = 32'sh7FFF_FFFF;
          default: n = 32'sh8000_0000;
        endcase
      end
      default: n = $urandom() >> $urandom_range(0, 31);
    endcase
    if (n != 32'sh8000_0000 && $urandom_range(0, 1)) n = -n;
    return n;
  endfunction

  function automatic logic [BASE_LEN_W-1:0] pick_radix();
    case ($urandom_range(0, 11))
      0: return 2;
      1: return 64;
      2: return BASE_LEN_W'($urandom_range(0, 1));
      3: return BASE_LEN_W'($urandom_range(65, 127));
      4: return 127;
      5: return 10;
      6: return 16;
      default: return BASE_LEN_W'($urandom_range(2, 64));
    endcase
  endfunction

  initial begin
    int                    goal;
    int                    n;
    logic [BASE_LEN_W-1:0] radix;
    logic [SYMBOL_W-1:0]   code;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Every alphabet slot is written up front so no conversion ever reads
    // a slot that holds no value: digits, lower case, upper case, '!' and 0xFF.
    for (int i = 0; i < MAX_BASE; i++) begin
      if (i < 10) code = SYMBOL_W'(32'h30 + i);
      else if (i < 36) code = SYMBOL_W'(32'h61 + i - 10);
      else if (i < 62) code = SYMBOL_W'(32'h41 + i - 36);
      else if (i == 62) code = 8'h21;
      else code = 8'hFF;
      load_symbol(i, code);
    end

    // Directed: radix 10 out of reset, zero, both ends of the number range
    convert(0);
    convert(-1);
    convert(32'sh7FFF_FFFF);
    convert(32'sh8000_0000);
    convert(-1234567890);
    // sign characters and a repeated symbol in use make the alphabet invalid
    load_symbol(3, CHAR_PLUS);
    convert(3);
    load_symbol(3, CHAR_MINUS);
    convert(-3);
    load_symbol(3, "5");
    convert(42);
    load_symbol(3, "3");
    // a zero byte is an ordinary digit symbol
    load_symbol(0, CHAR_NONE);
    convert(-100);
    load_symbol(0, "0");
    // a repeat outside the symbols in use is harmless ...
    load_symbol(20, "3");
    convert(20);
    write_radix(2);
    convert(32'sh8000_0000);
    // ... until the radix grows over it
    write_radix(64);
    convert(32'sh7FFF_FFFF);
    load_symbol(20, "k");
    convert(32'sh8000_0000);
    // radix below 2 or above the alphabet size
    write_radix(0);
    convert(5);
    write_radix(1);
    convert(-5);
    write_radix(65);
    convert(5);
    write_radix(127);
    convert(-5);

    // Random phases: new radix, repair the alphabet, then mostly conversions,
    // some clean symbol swaps and an occasional corrupting load.
    goal = sent_count + RANDOM_ITEMS;
    while (sent_count < goal) begin
      radix = pick_radix();
      write_radix(radix);
      quiet = (sent_count >= goal - QUIET_TAIL) || ($urandom_range(0, 3) == 0);
      if (radix >= 2 && radix <= MAX_BASE) repair_alphabet(int'(radix));
      n = $urandom_range(4, 10);
      repeat (n) begin
        maybe_pause();
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: convert(pick_number());
          6, 7, 8: load_symbol($urandom_range(0, MAX_BASE - 1), fresh_code());
          default: begin
            case ($urandom_range(0, 3))
              0: code = CHAR_PLUS;
              1: code = CHAR_MINUS;
              2: code = shadow[$urandom_range(0, MAX_BASE - 1)];
              default: code = SYMBOL_W'($urandom_range(0, 255));
            endcase
            load_symbol($urandom_range(0, MAX_BASE - 1), code);
          end
        endcase
      end
    end

    // Drain: every owed character delivered, then a short settle
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/srf_pkg.sv
rtl/srf_ram.sv
rtl/srf_divider.sv
rtl/signed_radix_formatter.sv
test/tb_signed_radix_formatter.sv
